// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the line parser RTL.
// Included by the files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define AHLP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ahlp assertion failed");

// Next-cycle implication, disabled while reset is low
`define AHLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ahlp assertion failed");

`endif

// ===== rtl/core/ahlp_pkg.sv =====
// Shared types, character codes and parse phase codes for the hex line parser.
// No dependencies; imported by the parser core, the output buffer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ahlp_pkg;

  // Result kinds carried on the output tuser bit
  localparam logic KIND_WORD     = 1'b0;
  localparam logic KIND_TOO_LONG = 1'b1;

  // Parse phases of the current line
  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_SPACES = 3'd0;
  localparam logic [PhaseW-1:0] PH_SIGNED = 3'd1;
  localparam logic [PhaseW-1:0] PH_ZERO   = 3'd2;
  localparam logic [PhaseW-1:0] PH_PREFIX = 3'd3;
  localparam logic [PhaseW-1:0] PH_DIGITS = 3'd4;

  // Character codes
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_PLUS     = 8'h2B;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_UPPER_X  = 8'h58;
  localparam logic [7:0] CHAR_LOWER_X  = 8'h78;
  localparam logic [7:0] CHAR_PRINT_HI = 8'h7E;

  localparam logic [31:0] SAT_WORD = 32'hFFFF_FFFF;

  // One result beat
  typedef struct packed {
    logic        kind;
    logic [31:0] word;
  } result_t;

  // Decoded hex digit
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok  = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ahlp_parse.sv =====
// Parser core: holds the per-line parse state and judges each accepted byte.
// Depends on ahlp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ahlp_parse #(
  parameter int unsigned LINE_BUFFER_BYTES = 64
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    beat_i,      // a byte is accepted this cycle
  input  wire  [7:0]             byte_i,
  output logic                   res_valid_o,
  output ahlp_pkg::result_t      res_o
);
  import ahlp_pkg::*;

  localparam int unsigned CntW = $clog2(LINE_BUFFER_BYTES);
  localparam logic [CntW-1:0] MAX_CNT = CntW'(LINE_BUFFER_BYTES - 1);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [31:0]       acc_q, acc_d;
  logic              neg_q, neg_d;
  logic              ovf_q, ovf_d;
  logic              inv_q, inv_d;

  hex_t        hx;
  logic        is_sign;
  logic        printable;
  logic        line_ok;
  logic [31:0] line_word;

  assign hx        = hex_decode(byte_i);
  assign is_sign   = (byte_i == CHAR_PLUS) || (byte_i == CHAR_MINUS);
  assign printable = (byte_i >= CHAR_SPACE) && (byte_i <= CHAR_PRINT_HI);
  assign line_ok   = !inv_q && ((phase_q == PH_ZERO) || (phase_q == PH_DIGITS));

  // Final word of the line: saturate, else apply the sign
  always_comb begin
    if (ovf_q) begin
      line_word = SAT_WORD;
    end else if (neg_q) begin
      line_word = 32'd0 - acc_q;
    end else begin
      line_word = acc_q;
    end
  end

  // Next parse state and result for the accepted byte
  always_comb begin
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    ovf_d       = ovf_q;
    inv_d       = inv_q;
    res_valid_o = 1'b0;
    res_o.kind  = KIND_WORD;
    res_o.word  = 32'd0;

    if (beat_i && byte_i != CHAR_CR) begin
      if (byte_i == CHAR_LF) begin
        // End of line: deliver the word if well formed, then clear
        res_valid_o = line_ok;
        res_o.word  = line_word;
        cnt_d       = '0;
        phase_d     = PH_SPACES;
        acc_d       = 32'd0;
        neg_d       = 1'b0;
        ovf_d       = 1'b0;
        inv_d       = 1'b0;
      end else if (printable) begin
        if (cnt_q < MAX_CNT) begin
          cnt_d = cnt_q + CntW'(1);
          if (!inv_q) begin
            if (phase_q == PH_SPACES && (byte_i == CHAR_SPACE || is_sign)) begin
              // Skip leading space, or take the sign
              if (is_sign) begin
                neg_d   = (byte_i == CHAR_MINUS);
                phase_d = PH_SIGNED;
              end
            end else begin
              case (phase_q)
                PH_SPACES, PH_SIGNED: begin
                  if (byte_i == CHAR_ZERO) begin
                    phase_d = PH_ZERO;
                  end else if (hx.ok) begin
                    acc_d   = {acc_q[27:0], hx.val};
                    ovf_d   = ovf_q | (acc_q[31:28] != 4'd0);
                    phase_d = PH_DIGITS;
                  end else begin
                    inv_d = 1'b1;
                  end
                end
                PH_ZERO: begin
                  if (byte_i == CHAR_LOWER_X || byte_i == CHAR_UPPER_X) begin
                    phase_d = PH_PREFIX;
                  end else if (hx.ok) begin
                    acc_d   = {acc_q[27:0], hx.val};
                    ovf_d   = ovf_q | (acc_q[31:28] != 4'd0);
                    phase_d = PH_DIGITS;
                  end else begin
                    inv_d = 1'b1;
                  end
                end
                PH_PREFIX, PH_DIGITS: begin
                  if (hx.ok) begin
                    acc_d   = {acc_q[27:0], hx.val};
                    ovf_d   = ovf_q | (acc_q[31:28] != 4'd0);
                    phase_d = PH_DIGITS;
                  end else begin
                    inv_d = 1'b1;
                  end
                end
                default: begin
                  inv_d = 1'b1;
                end
              endcase
            end
          end
        end else begin
          // Line too long: drop the byte, clear, report
          res_valid_o = 1'b1;
          res_o.kind  = KIND_TOO_LONG;
          cnt_d       = '0;
          phase_d     = PH_SPACES;
          acc_d       = 32'd0;
          neg_d       = 1'b0;
          ovf_d       = 1'b0;
          inv_d       = 1'b0;
        end
      end
    end
  end

  // Hold the line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= PH_SPACES;
      acc_q   <= 32'd0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      inv_q   <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
      inv_q   <= inv_d;
    end
  end

  `AHLP_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= MAX_CNT)
  `AHLP_ASSERT_NOW(a_err_zero, clk_i, rst_ni, res_valid_o && res_o.kind == KIND_TOO_LONG,
                   res_o.word == 32'd0)
  `AHLP_ASSERT_NEXT(a_clear_after, clk_i, rst_ni, res_valid_o,
                    cnt_q == '0 && phase_q == PH_SPACES && !inv_q && !ovf_q)

endmodule

`default_nettype wire

// ===== rtl/core/ahlp_skid.sv =====
// Output register with one skid entry, parting the parser from the result channel.
// Depends on ahlp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ahlp_skid (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  input  wire ahlp_pkg::result_t in_data_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output ahlp_pkg::result_t      out_data_o,
  input  wire                    out_ready_i
);
  import ahlp_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    drain;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign drain       = out_ready_i || !out_valid_q;

  // Refill output from skid entry first, else from the parser; if held, fill skid
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (drain) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d  = in_valid_i;
        out_d        = in_data_i;
      end
    end else if (in_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `AHLP_ASSERT_NOW(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `AHLP_ASSERT_NOW(a_no_write_full, clk_i, rst_ni, in_valid_i, !skid_valid_q)
  `AHLP_ASSERT_NEXT(a_skid_to_out, clk_i, rst_ni, skid_valid_q && out_ready_i,
                    out_valid_q && out_q == $past(skid_q))

endmodule

`default_nettype wire

// ===== rtl/core/ascii_hex_line_parser.sv =====
// ASCII hex line parser, one received byte in per beat, at most one result per byte.
// Slave channel: s_axis_tvalid/tready/tdata carry raw bytes.
// Master channel: m_axis_tvalid/tready/tdata/tuser carry results; tuser is the kind
// (0 = parsed 32-bit word, 1 = line too long, tdata zero).
// Each LF judges the line: leading spaces, optional sign, optional 0x prefix, hex digits.
// A well formed line emits its word (saturated on overflow, negated on minus);
// a blank or malformed line emits nothing. CR and unprintable bytes are ignored.
// The byte that would reach LINE_BUFFER_BYTES characters is dropped with an error beat.
// Throughput: one byte per cycle while s_axis_tready is high; the parse state updates in the accept cycle.
// A result is registered in the output register, or in the skid entry while the output is held.
// Stall: an output register plus one skid entry buffer results; s_axis_tready falls
// only while the skid entry is full, and rises the cycle after the receiver takes a beat.
// Reset (rst_ni low, asynchronous) clears the line state and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module ascii_hex_line_parser #(
  parameter int unsigned LINE_BUFFER_BYTES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] parsed_word
  output logic [0:0]  m_axis_tuser    // [0] result_kind
);
  import ahlp_pkg::*;

  logic    beat;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign beat = s_axis_tvalid && s_axis_tready;

  ahlp_parse #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .byte_i      (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ahlp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready)
  );

  // Unpack the result beat
  assign m_axis_tdata    = out_res.word;
  assign m_axis_tuser[0] = out_res.kind;

endmodule

`default_nettype wire

// ===== tb/tb_ascii_hex_line_parser.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the ASCII hex line parser: directed lines, then random traffic.
// Predicts result beats from its own parse model or the row tables; needs ahlp_pkg and the parser RTL.

module tb_ascii_hex_line_parser;
  import ahlp_pkg::*;

  localparam int LINE_BYTES   = 64;
  localparam int RAND_ITEMS   = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DIR_ROWS     = 24;

  // Hex letter and digit bounds not provided by the package
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  // How a directed row is checked
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_WORD, CHK_LONG} row_check_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [31:0] parsed_word
  logic [0:0]  m_axis_tuser;           // [0] result_kind

  // Results the parser still owes, oldest first
  result_t     word_q[$];
  logic [7:0]  byte_q[$];
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fed_cnt   = 0;
  logic        calm      = 1'b0;
  logic        typed_row = 1'b0;

  // Line state of the prediction
  int                line_len  = 0;
  logic [PhaseW-1:0] line_phase = PH_SPACES;
  logic [31:0]       line_acc  = '0;
  logic              line_neg  = 1'b0;
  logic              line_ovf  = 1'b0;
  logic              line_bad  = 1'b0;

  // Directed lines; LF is appended to each, pad gives leading spaces
  string dir_text [DIR_ROWS] = '{
    "", "   ", "0", "-0", "FFFFFFFF", "0xffffffff", "100000000", "-100000000",
    "-1", "+0X7fFfFfFf", "  -0x80000000", "0x", "12 ", "- 5", "+-5", "12g4",
    "x5", "-", "00x5", "\r1\0012\3773\1774\037", "0x0123456789abcdefABCDEF",
    "00000000123", "1F", "1F"
  };
  int dir_pad [DIR_ROWS] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    LINE_BYTES - 3, LINE_BYTES - 2
  };
  row_check_e dir_check [DIR_ROWS] = '{
    CHK_NONE, CHK_NONE, CHK_WORD, CHK_WORD, CHK_WORD, CHK_WORD, CHK_WORD, CHK_WORD,
    CHK_WORD, CHK_PRED, CHK_PRED, CHK_NONE, CHK_NONE, CHK_NONE, CHK_NONE, CHK_NONE,
    CHK_NONE, CHK_NONE, CHK_PRED, CHK_PRED, CHK_PRED, CHK_PRED, CHK_WORD, CHK_LONG
  };
  logic [31:0] dir_word [DIR_ROWS] = '{
    32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SAT_WORD, SAT_WORD,
    32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1F, 32'h0
  };

  ascii_hex_line_parser #(
    .LINE_BUFFER_BYTES(LINE_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Count cycles, open idle-free stretches, stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    calm      <= (cycle_cnt % 700) < 120;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_ascii_hex_line_parser: FAIL");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long, none in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Value of a hex digit, or -1
  function automatic int digit_of(logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CH_NINE) return int'(c - CHAR_ZERO);
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] rand_digit();
    int d;
    d = $urandom_range(0, 21);
    if (d < 10) return CHAR_ZERO + 8'(d);
    if (d < 16) return CH_LOWER_A + 8'(d - 10);
    return CH_UPPER_A + 8'(d - 16);
  endfunction

  task automatic reset_line();
    line_len   = 0;
    line_phase = PH_SPACES;
    line_acc   = '0;
    line_neg   = 1'b0;
    line_ovf   = 1'b0;
    line_bad   = 1'b0;
  endtask

  // Advance the line state by one accepted byte and queue the result it causes, unless the row is typed
  task automatic predict_byte(input logic [7:0] c);
    result_t res;
    int      d;
    logic    ok;
    logic    taken;
    d     = digit_of(c);
    taken = 1'b0;
    if (c == CHAR_CR) return;
    if (c == CHAR_LF) begin
      ok       = !line_bad && (line_phase == PH_ZERO || line_phase == PH_DIGITS);
      res.kind = KIND_WORD;
      res.word = line_ovf ? SAT_WORD : (line_neg ? 32'd0 - line_acc : line_acc);
      reset_line();
      if (ok && !typed_row) word_q.push_back(res);
      return;
    end
    if (c < CHAR_SPACE || c > CHAR_PRINT_HI) return;
    if (line_len >= LINE_BYTES - 1) begin
      reset_line();
      res.kind = KIND_TOO_LONG;
      res.word = '0;
      if (!typed_row) word_q.push_back(res);
      return;
    end
    line_len++;
    if (line_bad) return;
    // Leading spaces, then an optional sign
    if (line_phase == PH_SPACES) begin
      if (c == CHAR_SPACE) return;
      line_phase = PH_SIGNED;
      if (c == CHAR_PLUS || c == CHAR_MINUS) begin
        line_neg = (c == CHAR_MINUS);
        return;
      end
    end
    // Zero that may open a prefix, then the prefix letter
    case (line_phase)
      PH_SIGNED: if (c == CHAR_ZERO) begin
        line_phase = PH_ZERO;
        taken      = 1'b1;
      end
      PH_ZERO: if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
        line_phase = PH_PREFIX;
        taken      = 1'b1;
      end
      default: ;
    endcase
    if (taken) return;
    // Shift in a digit, flag anything else
    if (d >= 0) begin
      if (line_acc > 32'h0FFF_FFFF) line_ovf = 1'b1;
      line_acc   = {line_acc[27:0], 4'(d)};
      line_phase = PH_DIGITS;
    end else begin
      line_bad = 1'b1;
    end
  endtask

  // Drive the queued bytes one beat at a time, with random gaps
  task automatic send_queued();
    int gap;
    foreach (byte_q[i]) begin
      gap = pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= byte_q[i];
      do @(posedge clk_i); while (!s_axis_tready);
      predict_byte(byte_q[i]);
      if (byte_q[i] == CHAR_LF || (byte_q[i] >= CHAR_SPACE && byte_q[i] <= CHAR_PRINT_HI))
        fed_cnt++;
      @(negedge clk_i);
    end
    byte_q = {};
  endtask

  // Stall the result side at random
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (word_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected beat, expected none, actual kind %0d word %h",
                 $time, m_axis_tuser[0], m_axis_tdata);
      end else begin
        want = word_q.pop_front();
        if (want.kind !== m_axis_tuser[0]) begin
          err_cnt++;
          $display("%0t: kind mismatch, expected %0d, actual %0d",
                   $time, want.kind, m_axis_tuser[0]);
        end
        if (want.word !== m_axis_tdata) begin
          err_cnt++;
          $display("%0t: word mismatch, expected %h, actual %h",
                   $time, want.word, m_axis_tdata);
        end
      end
    end
  end

  initial begin
    result_t    res;
    int         sel;
    int         pre_len;
    int         ndig;
    logic [7:0] junk;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows; typed rows queue their own expectation up front
    for (int r = 0; r < DIR_ROWS; r++) begin
      repeat (dir_pad[r]) byte_q.push_back(CHAR_SPACE);
      for (int k = 0; k < dir_text[r].len(); k++) byte_q.push_back(dir_text[r][k]);
      byte_q.push_back(CHAR_LF);
      typed_row = (dir_check[r] != CHK_PRED);
      if (dir_check[r] == CHK_WORD || dir_check[r] == CHK_LONG) begin
        res.kind = (dir_check[r] == CHK_LONG) ? KIND_TOO_LONG : KIND_WORD;
        res.word = dir_word[r];
        word_q.push_back(res);
      end
      send_queued();
      typed_row = 1'b0;
    end

    // Random lines: mostly well formed, some broken, some noise and overlong
    fed_cnt = 0;
    while (fed_cnt < RAND_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        repeat ($urandom_range(1, 24)) byte_q.push_back(8'($urandom));
      end else if (sel < 7) begin
        repeat ($urandom_range(LINE_BYTES - 6, LINE_BYTES + 6)) byte_q.push_back(rand_digit());
        byte_q.push_back(CHAR_LF);
      end else begin
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) byte_q.push_back(CHAR_SPACE);
        case ($urandom_range(0, 2))
          1: byte_q.push_back(CHAR_PLUS);
          2: byte_q.push_back(CHAR_MINUS);
          default: ;
        endcase
        if ($urandom_range(0, 1)) begin
          byte_q.push_back(CHAR_ZERO);
          byte_q.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
        end
        pre_len = byte_q.size();
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        repeat (ndig) byte_q.push_back(rand_digit());
        // Break one line in five
        if (sel < 27) begin
          case ($urandom_range(0, 3))
            0: byte_q[$urandom_range(0, byte_q.size() - 1)] =
                 8'($urandom_range(CHAR_SPACE, CHAR_PRINT_HI));
            1: byte_q.push_back(CHAR_SPACE);
            2: byte_q.insert($urandom_range(0, byte_q.size()),
                             8'($urandom_range(CHAR_SPACE, CHAR_PRINT_HI)));
            default: while (byte_q.size() > pre_len) void'(byte_q.pop_back());
          endcase
        end
        // Slip in a byte the parser must skip
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0: junk = CHAR_CR;
            1: junk = 8'($urandom_range(0, CHAR_LF - 1));
            2: junk = 8'($urandom_range(CHAR_LF + 1, CHAR_SPACE - 1));
            default: junk = 8'($urandom_range(CHAR_PRINT_HI + 1, 255));
          endcase
          byte_q.insert($urandom_range(0, byte_q.size()), junk);
        end
        byte_q.push_back(CHAR_LF);
      end
      send_queued();
    end

    // Drain outstanding results
    s_axis_tvalid <= 1'b0;
    while (word_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_ascii_hex_line_parser: PASS");
    end else begin
      $display("tb_ascii_hex_line_parser: FAIL");
    end
    $finish;
  end

endmodule
